### hw/rtl/tlvd_pkg.sv
// Package for the type/length/status packet deframer.
// Header layout constants and the result record shared by the parser and the top level.
// No dependencies.
`timescale 1ns / 1ps

package tlvd_pkg;

	// Header layout, in bytes, little-endian
	localparam int unsigned HDR_BYTES  = 8;
	localparam int unsigned TYPE_AT    = 0;
	localparam int unsigned LEN_AT     = 2;
	localparam int unsigned STATUS_AT  = 6;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned TYPE_W     = 16;
	localparam int unsigned LEN_W      = 32;
	localparam int unsigned STATUS_W   = 16;
	localparam int unsigned HDR_W      = HDR_BYTES * BYTE_W;
	localparam int unsigned HCNT_W     = $clog2(HDR_BYTES);

	localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HDR_BYTES - 1);

	// One result transaction as produced by the parser
	typedef struct packed {
		logic                fire;
		logic [TYPE_W-1:0]   packet_type;
		logic [STATUS_W-1:0] packet_status;
		logic [LEN_W-1:0]    payload_length;
		logic [BYTE_W-1:0]   payload_byte;
		logic                has_data;
		logic                end_of_packet;
	} result_t;

endpackage

### hw/rtl/tlvd_parser.sv
// Framing state of the deframer: header collection and payload byte count.
// Produces at most one result per byte stepped in. Depends on tlvd_pkg.
`timescale 1ns / 1ps

module tlvd_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [tlvd_pkg::BYTE_W-1:0]  stream_byte,
	output tlvd_pkg::result_t            res
);

	logic                        in_payload_q;
	logic [tlvd_pkg::HCNT_W-1:0] header_count_q;
	logic [tlvd_pkg::HDR_W-1:0]  header_shift_q;
	logic [tlvd_pkg::LEN_W-1:0]  bytes_remaining_q;

	logic                        in_payload_d;
	logic [tlvd_pkg::HCNT_W-1:0] header_count_d;
	logic [tlvd_pkg::HDR_W-1:0]  header_shift_d;
	logic [tlvd_pkg::LEN_W-1:0]  bytes_remaining_d;
	logic                        payload_now;
	logic [tlvd_pkg::LEN_W-1:0]  new_length;

	// Write a header byte into its lane, keep the other lanes and leave payload bytes out
	always_comb begin
		header_shift_d = header_shift_q;
		for (int i = 0; i < tlvd_pkg::HDR_BYTES; i++) begin
			if (!payload_now && header_count_q == tlvd_pkg::HCNT_W'(i)) begin
				header_shift_d[i*tlvd_pkg::BYTE_W +: tlvd_pkg::BYTE_W] = stream_byte;
			end
		end
	end

	assign new_length  = header_shift_d[tlvd_pkg::LEN_AT*tlvd_pkg::BYTE_W +: tlvd_pkg::LEN_W];
	// A payload flag with nothing left to count falls back to header collection
	assign payload_now = in_payload_q && (bytes_remaining_q != '0);

	// Next state and result
	always_comb begin
		in_payload_d      = 1'b0;
		header_count_d    = header_count_q;
		bytes_remaining_d = bytes_remaining_q;
		res               = '0;
		res.packet_type    = header_shift_d[tlvd_pkg::TYPE_AT*tlvd_pkg::BYTE_W +: tlvd_pkg::TYPE_W];
		res.packet_status  = header_shift_d[tlvd_pkg::STATUS_AT*tlvd_pkg::BYTE_W +:
			tlvd_pkg::STATUS_W];
		res.payload_length = new_length;
		if (payload_now) begin
			// Payload byte: count down, mark the final one
			bytes_remaining_d = bytes_remaining_q - tlvd_pkg::LEN_W'(1);
			in_payload_d      = (bytes_remaining_q != tlvd_pkg::LEN_W'(1));
			res.fire          = 1'b1;
			res.payload_byte  = stream_byte;
			res.has_data      = 1'b1;
			res.end_of_packet = (bytes_remaining_q == tlvd_pkg::LEN_W'(1));
		end else if (header_count_q == tlvd_pkg::HCNT_LAST) begin
			// Final header byte: load the count, or close an empty packet at once
			header_count_d    = '0;
			bytes_remaining_d = new_length;
			in_payload_d      = (new_length != '0);
			res.fire          = (new_length == '0);
			res.end_of_packet = 1'b1;
		end else begin
			header_count_d = header_count_q + tlvd_pkg::HCNT_W'(1);
		end
	end

	// Advance the framing state on each stepped byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q      <= 1'b0;
			header_count_q    <= '0;
			header_shift_q    <= '0;
			bytes_remaining_q <= '0;
		end else if (step) begin
			in_payload_q      <= in_payload_d;
			header_count_q    <= header_count_d;
			header_shift_q    <= payload_now ? header_shift_q : header_shift_d;
			bytes_remaining_q <= bytes_remaining_d;
		end
	end

endmodule

### hw/rtl/tlv_packet_deframer.sv
// Top level of the type/length/status packet deframer.
// Input register, framing parser and result register. Depends on tlvd_pkg, tlvd_parser.
`timescale 1ns / 1ps

// The deframer takes one stream byte per transaction and splits the stream into packets,
// each an 8-byte little-endian header (type, 32-bit length, status) followed by as many
// payload bytes as the length gives. Every payload byte leaves as one result transaction
// tagged with its packet's header fields, end_of_packet set on the last; a zero-length
// packet gives one result with has_data clear on its final header byte, and the other
// header bytes give none. One byte is taken every cycle while the output is not stalled;
// a byte is held in the input register, and its result is registered in the result
// register and presented on the output from there. The header/count update between
// the two registers is combinational, which is what allows a byte in every cycle.
module tlv_packet_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tlvd_pkg::BYTE_W-1:0]    stream_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tlvd_pkg::TYPE_W-1:0]    packet_type,
	output logic [tlvd_pkg::STATUS_W-1:0]  packet_status,
	output logic [tlvd_pkg::LEN_W-1:0]     payload_length,
	output logic [tlvd_pkg::BYTE_W-1:0]    payload_byte,
	output logic                           has_data,
	output logic                           end_of_packet
);

	logic                        valid_s1;
	logic [tlvd_pkg::BYTE_W-1:0] byte_s1;
	logic                        valid_s2;
	tlvd_pkg::result_t           res_s2;
	tlvd_pkg::result_t           res;
	logic                        s2_free;
	logic                        adv_s1;

	// A byte leaves stage 1 unless it makes a result with nowhere to go
	assign s2_free  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && (!res.fire || s2_free);
	assign in_stall = valid_s1 && !adv_s1;

	// Hold the accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= stream_byte;
		end
	end

	tlvd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.stream_byte (byte_s1),
		.res         (res)
	);

	// Load the result register whenever the output side has taken the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= adv_s1 && res.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && adv_s1 && res.fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign packet_type    = res_s2.packet_type;
	assign packet_status  = res_s2.packet_status;
	assign payload_length = res_s2.payload_length;
	assign payload_byte   = res_s2.payload_byte;
	assign has_data       = res_s2.has_data;
	assign end_of_packet  = res_s2.end_of_packet;

endmodule
